FILE: design/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

  localparam int QW       = 16;
  localparam int AW       = 16;
  localparam int FRAC     = QW - 2;
  localparam int PRESHIFT = 56 - QW;
  localparam int STEPS    = 30;
  // CORDIC datapath width: operands up to about 2^(QW+3) shifted by PRESHIFT,
  // gain 1.65, plus sign and guard
  localparam int CW       = 64;
  localparam int SQW      = 2 * QW;  // radicand width; the root has half as many bits
  localparam int RW       = QW + 2;  // rounded product width; sums and outputs are two bits wider

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [AW-1:0] roll_angle;
    logic signed [AW-1:0] pitch_angle;
    logic signed [AW-1:0] yaw_angle;
    logic                 pitch_saturated;
  } euler_t;

  // atan(2^-i)/pi * 2^31
  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0:  t = 32'd536870912; 5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907; 5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;  5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;  5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;   5'd9:  t = 32'd1335087;
      5'd10: t = 32'd667544;    5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;    5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;     5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;     5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;       5'd21: t = 32'd326;
      5'd22: t = 32'd163;       5'd23: t = 32'd81;
      5'd24: t = 32'd41;        5'd25: t = 32'd20;
      5'd26: t = 32'd10;        5'd27: t = 32'd5;
      5'd28: t = 32'd3;         5'd29: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  // 32-bit binary angle to AW bits, rounded
  function automatic logic [AW-1:0] to_angle(input logic [31:0] z);
    logic [32:0] s;
    s = {1'b0, z} + 33'((33'd1 << (32 - AW)) >> 1);
    return s[31 -: AW];
  endfunction

endpackage

FILE: design/qte_cordic.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC atan2, one iteration per stage, STEPS+1 stages.
// Advances when en_i is high.
module qte_cordic import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [RW+1:0] y_i,
  input  logic signed [RW+1:0] x_i,
  output logic [31:0]          z_o
);

  logic signed [CW-1:0] x_q [STEPS+1];
  logic signed [CW-1:0] y_q [STEPS+1];
  logic [31:0]          z_q [STEPS+1];
  logic                 zero_q [STEPS+1];

  // prerotation into the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -(CW'(x_i) <<< PRESHIFT);
        y_q[0] <= -(CW'(y_i) <<< PRESHIFT);
        z_q[0] <= 32'h8000_0000;
      end else begin
        x_q[0] <= CW'(x_i) <<< PRESHIFT;
        y_q[0] <= CW'(y_i) <<< PRESHIFT;
        z_q[0] <= '0;
      end
    end
  end

  // micro-rotations
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_tab(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_tab(5'(i));
        end
      end
    end
  end

  assign z_o = zero_q[STEPS] ? '0 : z_q[STEPS];

endmodule

FILE: design/qte_front.sv
`timescale 1ns / 1ps
// Front end: products (stage 1), sums (stage 2), pitch radicand and
// saturation (stage 3), then a restoring root one bit per stage.
module qte_front import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  quat_t                q_i,
  output logic signed [RW+1:0] sr_o,
  output logic signed [RW+1:0] cr_o,
  output logic signed [RW+1:0] sp_o,
  output logic signed [RW+1:0] cp_o,
  output logic signed [RW+1:0] sy_o,
  output logic signed [RW+1:0] cy_o,
  output logic                 sat_o,
  output logic                 sat_neg_o
);

  localparam int NB = SQW / 2;  // root bits
  localparam int PW = 2 * QW;

  function automatic logic signed [RW-1:0] mr(input logic signed [QW-1:0] a,
                                               input logic signed [QW-1:0] b);
    logic signed [PW:0] p;
    p = PW'(a) * PW'(b) + (PW+1)'(1 <<< (FRAC - 1));
    return RW'(p >>> FRAC);
  endfunction

  // stage 1: rounded products
  logic signed [RW-1:0] wx_q, yz_q, wy_q, zx_q, wz_q, xy_q, xx_q, yy_q, zz_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= mr(q_i.quat_w, q_i.quat_x); yz_q <= mr(q_i.quat_y, q_i.quat_z);
      wy_q <= mr(q_i.quat_w, q_i.quat_y); zx_q <= mr(q_i.quat_z, q_i.quat_x);
      wz_q <= mr(q_i.quat_w, q_i.quat_z); xy_q <= mr(q_i.quat_x, q_i.quat_y);
      xx_q <= mr(q_i.quat_x, q_i.quat_x); yy_q <= mr(q_i.quat_y, q_i.quat_y);
      zz_q <= mr(q_i.quat_z, q_i.quat_z);
    end
  end

  // stage 2: sums
  localparam logic signed [RW+1:0] ONE = (RW+2)'(1) <<< FRAC;
  logic signed [RW+1:0] sr2_q, cr2_q, sp2_q, sy2_q, cy2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr2_q <= ((RW+2)'(wx_q) + (RW+2)'(yz_q)) <<< 1;
      cr2_q <= ONE - (((RW+2)'(xx_q) + (RW+2)'(yy_q)) <<< 1);
      sp2_q <= ((RW+2)'(wy_q) - (RW+2)'(zx_q)) <<< 1;
      sy2_q <= ((RW+2)'(wz_q) + (RW+2)'(xy_q)) <<< 1;
      cy2_q <= ONE - (((RW+2)'(yy_q) + (RW+2)'(zz_q)) <<< 1);
    end
  end

  // stage 3: saturation and radicand (sp^2 fits: |sp| < ONE when used)
  logic signed [RW+1:0] sr3_q, cr3_q, sp3_q, sy3_q, cy3_q;
  logic                 sat3_q, neg3_q;
  logic [SQW-1:0]       rad3_q;
  logic [FRAC:0]        spa;
  assign spa = sp2_q[RW+1] ? (FRAC+1)'(-sp2_q) : (FRAC+1)'(sp2_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr3_q <= sr2_q; cr3_q <= cr2_q; sp3_q <= sp2_q;
      sy3_q <= sy2_q; cy3_q <= cy2_q;
      sat3_q <= (sp2_q >= ONE) || (sp2_q <= -ONE);
      neg3_q <= sp2_q[RW+1];
      rad3_q <= SQW'((SQW'(1) << (2 * FRAC)) - SQW'(spa) * SQW'(spa));
    end
  end

  // root pipeline: one result bit per stage
  logic [SQW-1:0]       rm_q [NB+1];
  logic [NB-1:0]        rt_q [NB+1];
  logic signed [RW+1:0] d_sr [NB+1], d_cr [NB+1], d_sp [NB+1];
  logic signed [RW+1:0] d_sy [NB+1], d_cy [NB+1];
  logic                 d_sat [NB+1], d_neg [NB+1];

  always_comb begin
    rm_q[0] = rad3_q; rt_q[0] = '0;
    d_sr[0] = sr3_q; d_cr[0] = cr3_q; d_sp[0] = sp3_q;
    d_sy[0] = sy3_q; d_cy[0] = cy3_q; d_sat[0] = sat3_q; d_neg[0] = neg3_q;
  end

  for (genvar k = 0; k < NB; k++) begin : g_root
    localparam int B = NB - 1 - k;
    logic [SQW+1:0] trial;
    // (4 * root + 1) scaled to the bit under test
    assign trial = (SQW+2)'({rt_q[k], 2'b01}) << (2 * B);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ((SQW+2)'(rm_q[k]) >= trial) begin
          rm_q[k+1] <= SQW'((SQW+2)'(rm_q[k]) - trial);
          rt_q[k+1] <= {rt_q[k][NB-2:0], 1'b1};
        end else begin
          rm_q[k+1] <= rm_q[k];
          rt_q[k+1] <= {rt_q[k][NB-2:0], 1'b0};
        end
        d_sr[k+1] <= d_sr[k]; d_cr[k+1] <= d_cr[k]; d_sp[k+1] <= d_sp[k];
        d_sy[k+1] <= d_sy[k]; d_cy[k+1] <= d_cy[k];
        d_sat[k+1] <= d_sat[k]; d_neg[k+1] <= d_neg[k];
      end
    end
  end

  assign sr_o = d_sr[NB]; assign cr_o = d_cr[NB];
  assign sp_o = d_sp[NB]; assign sy_o = d_sy[NB]; assign cy_o = d_cy[NB];
  assign cp_o = (RW+2)'(rt_q[NB]);
  assign sat_o = d_sat[NB];
  assign sat_neg_o = d_neg[NB];

endmodule

FILE: design/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Three arithmetic stages, a 16-stage square root and a 31-stage CORDIC lie
// between an accepted item and its result. Throughput: one item per cycle
// unless a held result is stalled; all stages are fully pipelined. A stall
// on the output with a valid result held freezes the whole pipe; nothing is lost.
// Reset (rst_ni low, asynchronous) clears all valid bits; data is not reset.
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  quat_t  in_data_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output euler_t out_data_o
);

  localparam int LAT = 3 + QW + STEPS + 1;

  logic en;
  logic [LAT-1:0] vld_q;
  // pipe advances unless a valid result is held
  assign en = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic signed [RW+1:0] sr, cr, sp, cp, sy, cy;
  logic sat, sneg;
  qte_front u_front (.clk_i, .en_i(en), .q_i(in_data_i), .sr_o(sr), .cr_o(cr),
    .sp_o(sp), .cp_o(cp), .sy_o(sy), .cy_o(cy), .sat_o(sat), .sat_neg_o(sneg));

  logic [31:0] zr, zp, zy;
  qte_cordic u_roll  (.clk_i, .en_i(en), .y_i(sr), .x_i(cr), .z_o(zr));
  qte_cordic u_pitch (.clk_i, .en_i(en), .y_i(sp), .x_i(cp), .z_o(zp));
  qte_cordic u_yaw   (.clk_i, .en_i(en), .y_i(sy), .x_i(cy), .z_o(zy));

  // saturation flags ride alongside the pitch CORDIC
  logic [STEPS:0] sat_q, neg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q <= {sat_q[STEPS-1:0], sat};
      neg_q <= {neg_q[STEPS-1:0], sneg};
    end
  end

  localparam logic [AW-1:0] QUARTER = AW'(1) << (AW - 2);
  always_comb begin
    out_data_o.roll_angle      = to_angle(zr);
    out_data_o.yaw_angle       = to_angle(zy);
    out_data_o.pitch_saturated = sat_q[STEPS];
    if (sat_q[STEPS]) begin
      out_data_o.pitch_angle = neg_q[STEPS] ? -QUARTER : QUARTER;
    end else begin
      out_data_o.pitch_angle = to_angle(zp);
    end
  end
  assign out_valid_o = vld_q[LAT-1];

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("spurious stall");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("held result changed");
  a_sat_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pitch_saturated) |->
    (out_data_o.pitch_angle == QUARTER || out_data_o.pitch_angle == -QUARTER))
    else $error("saturated pitch not quarter turn");

endmodule

FILE: tb/quaternion_to_euler_angles_checker.sv
`timescale 1ns / 1ps
module quaternion_to_euler_angles_checker import qte_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_stall_i,
  input  quat_t  in_data_i,
  input  logic   out_valid_i,
  input  logic   out_stall_i,
  input  euler_t out_data_i,
  output int     err_count_o,
  output int     pending_o
);

  euler_t angles_q[$];

  // floor division by 2^s; >>> on signed longint is an arithmetic shift
  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fl_shr(a * b + (longint'(1) << (FRAC - 1)), FRAC);
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring CORDIC, 32-bit binary angle with 2^31 = pi
  function automatic logic [31:0] vec_angle(longint y, longint x);
    logic [31:0] a;
    longint dx;
    longint dy;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = 32'h8000_0000;
    end
    x = x <<< PRESHIFT;
    y = y <<< PRESHIFT;
    for (int i = 0; i < STEPS; i++) begin
      dx = fl_shr(y, i);
      dy = fl_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; a += atan_tab(5'(i));
      end else begin
        x -= dx; y += dy; a -= atan_tab(5'(i));
      end
    end
    return a;
  endfunction

  function automatic logic [AW-1:0] round_angle(logic [31:0] a);
    logic [32:0] s;
    s = {1'b0, a} + 33'(1 << (32 - AW - 1));
    return s[31 -: AW];
  endfunction

  function automatic euler_t quat_to_euler(quat_t q);
    longint w, x, y, z, one, xx, yy, zz, sr, cr, sp, sy, cy;
    euler_t e;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    one = longint'(1) << FRAC;
    xx = qmul(x, x); yy = qmul(y, y); zz = qmul(z, z);
    sr = 2 * (qmul(w, x) + qmul(y, z));
    cr = one - 2 * (xx + yy);
    sp = 2 * (qmul(w, y) - qmul(z, x));
    sy = 2 * (qmul(w, z) + qmul(x, y));
    cy = one - 2 * (yy + zz);
    e.roll_angle = round_angle(vec_angle(sr, cr));
    e.yaw_angle  = round_angle(vec_angle(sy, cy));
    if (sp >= one) begin
      e.pitch_angle = AW'(1 << (AW - 2));
      e.pitch_saturated = 1'b1;
    end else if (sp <= -one) begin
      e.pitch_angle = -AW'(1 << (AW - 2));
      e.pitch_saturated = 1'b1;
    end else begin
      e.pitch_angle = round_angle(vec_angle(sp, floor_sqrt(one * one - sp * sp)));
      e.pitch_saturated = 1'b0;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    err_count_o++;
  endtask

  initial err_count_o = 0;
  assign pending_o = angles_q.size();

  // predict on input, compare on output
  always @(posedge clk_i) begin
    euler_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) angles_q.push_back(quat_to_euler(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (angles_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          e = angles_q.pop_front();
          if (out_data_i.roll_angle !== e.roll_angle)
            report_mismatch("roll", out_data_i.roll_angle, e.roll_angle);
          if (out_data_i.pitch_angle !== e.pitch_angle)
            report_mismatch("pitch", out_data_i.pitch_angle, e.pitch_angle);
          if (out_data_i.yaw_angle !== e.yaw_angle)
            report_mismatch("yaw", out_data_i.yaw_angle, e.yaw_angle);
          if (out_data_i.pitch_saturated !== e.pitch_saturated)
            report_mismatch("saturated", out_data_i.pitch_saturated, e.pitch_saturated);
        end
      end
    end
  end

endmodule

FILE: tb/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 1ps
module quaternion_to_euler_angles_tb import qte_pkg::*;;

  localparam int RANDOM_ITEMS = 530;
  localparam int LAT = 50;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  quat_t  in_data_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  euler_t out_data_o;
  int     err_count;
  int     pending;
  bit     long_hold = 1'b0;
  bit     stim_done = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  quaternion_to_euler_angles i_dut (.*);

  quaternion_to_euler_angles_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .err_count_o(err_count), .pending_o(pending)
  );

  function automatic logic signed [QW-1:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'(int'($urandom));
      3: return 16'(int'($urandom_range(0, 40)) - 20);
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // unit quaternion from a random rotation; sometimes near gimbal lock
  function automatic quat_t unit_quat();
    real a, b, c, d, n;
    quat_t q;
    a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
    if ($urandom_range(0, 4) == 0) begin
      c = a; d = ($urandom_range(0, 1) ? b : -b) + $urandom_range(0, 4) - 2.0;
    end
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    q.quat_w = 16'($rtoi(16384.0 * a / n)); q.quat_x = 16'($rtoi(16384.0 * b / n));
    q.quat_y = 16'($rtoi(16384.0 * c / n)); q.quat_z = 16'($rtoi(16384.0 * d / n));
    return q;
  endfunction

  // valid stays up between back-to-back items; it drops only for a gap
  task automatic send_quat(quat_t q);
    int gap;
    gap = long_hold ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver stall: random per item, one long hold-off
  initial begin
    int waitc;
    @(posedge rst_ni);
    while (!stim_done) begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        long_hold = 1'b0;
      end
      waitc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (waitc != 0) begin
        out_stall_i <= 1'b1;
        repeat (waitc) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    quat_t q;
    logic signed [QW-1:0] ext[5];
    ext = '{16'sd16384, -16'sd16384, 16'sh7fff, 16'sh8000, 16'sd0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zeros, identity, extremes, gimbal lock, half turns
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    send_quat('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    send_quat('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
    send_quat('{16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
    send_quat('{16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192});
    send_quat('{16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192});
    for (int i = 0; i < 5; i++) send_quat('{ext[i], ext[i], ext[i], ext[i]});
    send_quat('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    send_quat('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    send_quat('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
    send_quat('{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});
    send_quat('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
    drain();
    // random: mostly unit quaternions, some raw component noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) long_hold = 1'b1;
      if (n == 350) drain();
      if ($urandom_range(0, 3) == 0) begin
        q.quat_w = pick_comp(); q.quat_x = pick_comp();
        q.quat_y = pick_comp(); q.quat_z = pick_comp();
      end else begin
        q = unit_quat();
      end
      send_quat(q);
    end
    drain();
    stim_done = 1'b1;
    repeat (LAT + 10) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
